// ===== sv/rbeq_pkg.sv =====
// Shared types, codes and helpers for the rotary button event qualifier.
package rbeq_pkg;

  // Input item kinds
  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // Result event kinds
  localparam logic [2:0] EV_CW      = 3'd0;
  localparam logic [2:0] EV_CCW     = 3'd1;
  localparam logic [2:0] EV_PRESS   = 3'd2;
  localparam logic [2:0] EV_SINGLE  = 3'd3;
  localparam logic [2:0] EV_DOUBLE  = 3'd4;
  localparam logic [2:0] EV_LONG    = 3'd5;
  localparam logic [2:0] EV_DISPLAY = 3'd6;
  localparam logic [2:0] EV_STATUS  = 3'd7;

  // Last-event codes
  localparam logic [2:0] LE_NONE    = 3'd0;
  localparam logic [2:0] LE_CW      = 3'd1;
  localparam logic [2:0] LE_CCW     = 3'd2;
  localparam logic [2:0] LE_PRESS   = 3'd3;
  localparam logic [2:0] LE_RELEASE = 3'd4;
  localparam logic [2:0] LE_DOUBLE  = 3'd5;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_LONG     = 2'd1;
  localparam logic [1:0] CFG_WINDOW   = 2'd2;
  localparam logic [1:0] CFG_DISPLAY  = 2'd3;

  localparam logic [15:0] DEBOUNCE_RST = 16'd20;
  localparam logic [15:0] LONG_RST     = 16'd1250;
  localparam logic [15:0] WINDOW_RST   = 16'd450;
  localparam logic [15:0] DISPLAY_RST  = 16'd100;

  // Result slots, in emission order
  localparam int NSLOT        = 6;
  localparam int SLOT_ROT     = 0;
  localparam int SLOT_EXPIRE  = 1;
  localparam int SLOT_BUTTON  = 2;
  localparam int SLOT_LONG    = 3;
  localparam int SLOT_DISPLAY = 4;
  localparam int SLOT_STATUS  = 5;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] click_window_ticks;
    logic [15:0] display_interval_ticks;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        now_ticks;
    logic               encoder_ok;
    logic signed [31:0] encoder_delta;
    logic signed [31:0] encoder_position;
    logic               button_ok;
    logic               button_level;
    logic               display_ready;
    logic signed [31:0] new_position;
  } in_item_t;

  typedef struct packed {
    logic [31:0] cur_position;
    logic [31:0] event_counter;
    logic [2:0]  evt_code;
    logic        debounced_state;
    logic        raw_prev;
    logic [31:0] raw_change_time;
    logic [31:0] press_start_time;
    logic        press_tracking;
    logic        long_fired;
    logic        long_feedback;
    logic [1:0]  click_counter;
    logic [31:0] click_start_time;
    logic        awaiting_click;
    logic [31:0] display_time;
    logic        display_pending;
    logic [31:0] display_position;
    logic [31:0] delta_sum;
  } state_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic signed [31:0] position;
    logic signed [31:0] delta;
    logic               btn_down;
    logic [31:0]        event_total;
    logic [2:0]         recent_code;
    logic               last;
  } res_t;

  // Build one result item; status fields are taken from the given state.
  function automatic res_t mk_res(logic [2:0] kind, logic [31:0] pos, logic [31:0] dl,
                                  state_t s, logic is_last);
    res_t r;
    r.event_kind     = kind;
    r.position       = pos;
    r.delta          = dl;
    r.btn_down       = s.debounced_state;
    r.event_total    = s.event_counter;
    r.recent_code    = s.evt_code;
    r.last           = is_last;
    return r;
  endfunction

endpackage

// ===== sv/rbeq_cfg.sv =====
// Configuration register file for the rotary button event qualifier.
module rbeq_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_i,
  input  logic [1:0]         idx_i,
  input  logic [15:0]        data_i,
  output rbeq_pkg::cfg_t     cfg_o
);
  import rbeq_pkg::*;

  cfg_t cfg_r;

  // Register writes; reset loads the default timings.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks         <= DEBOUNCE_RST;
      cfg_r.long_press_ticks       <= LONG_RST;
      cfg_r.click_window_ticks     <= WINDOW_RST;
      cfg_r.display_interval_ticks <= DISPLAY_RST;
    end else if (wr_i) begin
      unique case (idx_i)
        CFG_DEBOUNCE: cfg_r.debounce_ticks         <= data_i;
        CFG_LONG:     cfg_r.long_press_ticks       <= data_i;
        CFG_WINDOW:   cfg_r.click_window_ticks     <= data_i;
        CFG_DISPLAY:  cfg_r.display_interval_ticks <= data_i;
        default:      ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== sv/rbeq_eval.sv =====
// Single-pass evaluation of one input item: next state and all result slots.
module rbeq_eval (
  input  rbeq_pkg::in_item_t               item_i,
  input  rbeq_pkg::state_t                 st_i,
  input  rbeq_pkg::cfg_t                   cfg_i,
  output rbeq_pkg::state_t                 st_o,
  output rbeq_pkg::res_t [rbeq_pkg::NSLOT-1:0] slot_o,
  output logic [rbeq_pkg::NSLOT-1:0]       mask_o
);
  import rbeq_pkg::*;

  state_t      s;
  logic        raw;
  logic        rot;
  logic        cw;
  logic [31:0] d;
  logic [31:0] now;
  logic [1:0]  ccn;
  logic        mark;
  logic [31:0] dif_click;
  logic [31:0] dif_raw;
  logic [31:0] dif_long;
  logic [31:0] dif_disp;

  always_comb begin
    s         = st_i;
    now       = item_i.now_ticks;
    raw       = ~item_i.button_level;
    d         = 32'd0 - item_i.encoder_delta;
    cw        = ~d[31];
    rot       = 1'b0;
    ccn       = 2'd0;
    mark      = 1'b0;
    dif_click = now - st_i.click_start_time;
    dif_raw   = now - st_i.raw_change_time;
    dif_long  = 32'd0;
    dif_disp  = now - st_i.display_time;
    mask_o    = '0;
    slot_o    = '0;

    if (item_i.kind == KIND_SET) begin
      // Set position: store negated value and report it at once.
      s.cur_position = 32'd0 - item_i.new_position;
      slot_o[SLOT_STATUS] = mk_res(EV_DISPLAY, s.cur_position, 32'd0, s, 1'b1);
      mask_o[SLOT_STATUS] = 1'b1;
    end else begin
      // Rotation with reversed direction.
      rot = item_i.encoder_ok && (item_i.encoder_delta != 32'sd0);
      if (rot) begin
        s.cur_position    = 32'd0 - item_i.encoder_position;
        s.event_counter   = s.event_counter + 32'd1;
        s.evt_code        = cw ? LE_CW : LE_CCW;
        slot_o[SLOT_ROT]  = mk_res(cw ? EV_CW : EV_CCW, s.cur_position, d, s, 1'b0);
        mask_o[SLOT_ROT]  = 1'b1;
        s.display_position = s.cur_position;
        s.delta_sum        = s.delta_sum + d;
        s.display_pending  = 1'b1;
      end

      if (item_i.button_ok) begin
        // Click window ran out: the waiting click is a single click.
        if (s.awaiting_click && s.click_counter == 2'd1 &&
            dif_click >= 32'(cfg_i.click_window_ticks)) begin
          s.awaiting_click    = 1'b0;
          s.click_counter     = 2'd0;
          slot_o[SLOT_EXPIRE] = mk_res(EV_SINGLE, s.cur_position, 32'd0, s, 1'b0);
          mask_o[SLOT_EXPIRE] = 1'b1;
        end

        // Raw edge restarts the debounce; a stable level is accepted.
        if (raw != s.raw_prev) begin
          s.raw_change_time = now;
          s.raw_prev        = raw;
          s.long_fired      = 1'b0;
          if (raw) begin
            s.press_start_time = now;
            s.press_tracking   = 1'b1;
            s.long_feedback    = 1'b0;
          end else begin
            s.press_tracking = 1'b0;
            if (s.long_feedback) begin
              s.long_feedback = 1'b0;
              mark            = 1'b1;
            end
          end
        end else if (raw != s.debounced_state &&
                     dif_raw >= 32'(cfg_i.debounce_ticks)) begin
          s.debounced_state = raw;
          s.event_counter   = s.event_counter + 32'd1;
          s.evt_code        = raw ? LE_PRESS : LE_RELEASE;
          mask_o[SLOT_BUTTON] = 1'b1;
          if (!raw) begin
            ccn = s.click_counter + 2'd1;
            if (ccn == 2'd2) begin
              if (dif_click < 32'(cfg_i.click_window_ticks)) begin
                s.awaiting_click  = 1'b0;
                s.click_counter   = 2'd0;
                s.evt_code        = LE_DOUBLE;
                slot_o[SLOT_BUTTON] = mk_res(EV_DOUBLE, s.cur_position, 32'd0, s, 1'b0);
              end else begin
                slot_o[SLOT_BUTTON] = mk_res(EV_SINGLE, s.cur_position, 32'd0, s, 1'b0);
                s.click_counter    = 2'd1;
                s.click_start_time = now;
                s.awaiting_click   = 1'b1;
              end
            end else begin
              mask_o[SLOT_BUTTON] = 1'b0;
              s.click_counter    = 2'd1;
              s.click_start_time = now;
              s.awaiting_click   = 1'b1;
            end
          end else begin
            slot_o[SLOT_BUTTON] = mk_res(EV_PRESS, s.cur_position, 32'd0, s, 1'b0);
          end
          mark = 1'b1;
        end

        // Long press, timed from the raw press edge.
        dif_long = now - s.press_start_time;
        if (raw && s.debounced_state && !s.long_fired && s.press_tracking &&
            dif_long >= 32'(cfg_i.long_press_ticks)) begin
          s.long_fired      = 1'b1;
          s.long_feedback   = 1'b1;
          slot_o[SLOT_LONG] = mk_res(EV_LONG, s.cur_position, 32'd0, s, 1'b0);
          mask_o[SLOT_LONG] = 1'b1;
          mark              = 1'b1;
        end

        if (mark) begin
          s.display_position = s.cur_position;
          s.display_pending  = 1'b1;
        end
      end

      // Rate-limited display update.
      if (s.display_pending && dif_disp >= 32'(cfg_i.display_interval_ticks) &&
          item_i.display_ready) begin
        slot_o[SLOT_DISPLAY] = mk_res(EV_DISPLAY, s.display_position, s.delta_sum, s, 1'b0);
        mask_o[SLOT_DISPLAY] = 1'b1;
        s.display_time       = now;
        s.delta_sum          = 32'd0;
        s.display_pending    = 1'b0;
      end

      // Every poll closes with a status item.
      slot_o[SLOT_STATUS] = mk_res(EV_STATUS, s.cur_position, 32'd0, s, 1'b1);
      mask_o[SLOT_STATUS] = 1'b1;
    end

    st_o = s;
  end

endmodule

// ===== sv/rbeq_outbuf.sv =====
// Result buffer: holds the slots of one item and sends them one per cycle while out_tready is high.
module rbeq_outbuf (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load_i,
  input  rbeq_pkg::res_t [rbeq_pkg::NSLOT-1:0] slot_i,
  input  logic [rbeq_pkg::NSLOT-1:0]           mask_i,
  output logic                                 free_o,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output rbeq_pkg::res_t                       res_o
);
  import rbeq_pkg::*;

  res_t [NSLOT-1:0] slot_r;
  logic [NSLOT-1:0] vld_r;
  logic [NSLOT-1:0] vld_nxt;
  logic [NSLOT-1:0] first;
  logic             found;

  // Pick the lowest valid slot.
  always_comb begin
    first = '0;
    found = 1'b0;
    res_o = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (vld_r[i] && !found) begin
        first[i] = 1'b1;
        found    = 1'b1;
        res_o    = slot_r[i];
      end
    end
  end

  assign out_tvalid = |vld_r;

  // Slots left after this cycle's handshake; the buffer is free when none remain.
  always_comb begin
    vld_nxt = vld_r & ~((out_tvalid && out_tready) ? first : '0);
    free_o  = (vld_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (load_i) begin
      vld_r <= mask_i;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      slot_r <= slot_i;
    end
  end

endmodule

// ===== sv/rotary_button_event_qualifier.sv =====
// Top level of the rotary button event qualifier.
//
// Usage: poll items and set-position items arrive on the in_ stream (in_tuser
// selects the kind). Each accepted item is captured in an input register and,
// once the result buffer is free, evaluated in a single pass that updates all
// state and fills a six-slot result buffer. The buffer sends result items on
// the out_ stream, one per cycle while out_tready is high; out_tlast marks the
// final item of each input.
// A poll produces 1 to 6 result items and a set-position item produces one.
// A new item is taken into the input register while results of the previous
// item still drain, and it is evaluated in the cycle the buffer's last item
// leaves. Registers are written on the cfg_ stream (always ready); the user
// must write them only while idle, as the block itself does not enforce it.
// Reset (synchronous, rst_n low) clears all state and restores the default
// timings. When the receiver stalls, the current result holds and the input
// register, once full, stops accepting.
module rotary_button_event_qualifier (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // now_ticks, encoder_ok, encoder_delta, encoder_position, button_ok,
  // button_level, display_ready, new_position (from bit 0 up), zero fill
  input  logic [135:0] in_tdata,
  // kind
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // position, delta, btn_down, event_total, recent_code (from bit 0 up),
  // zero fill
  output logic [103:0] out_tdata,
  // event_kind
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import rbeq_pkg::*;

  cfg_t             cfg;
  in_item_t         item_r;
  logic             in_valid_r;
  state_t           state_r;
  state_t           state_nxt;
  res_t [NSLOT-1:0] slots;
  logic [NSLOT-1:0] mask;
  logic             buf_free;
  logic             load;
  res_t             res;

  assign cfg_ready = 1'b1;

  rbeq_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (cfg_valid && cfg_ready),
    .idx_i  (cfg_index),
    .data_i (cfg_data),
    .cfg_o  (cfg)
  );

  // Input register: refills while its item moves into the result buffer.
  assign load      = in_valid_r && buf_free;
  assign in_tready = !in_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind             <= in_tuser;
      item_r.now_ticks        <= in_tdata[31:0];
      item_r.encoder_ok       <= in_tdata[32];
      item_r.encoder_delta    <= in_tdata[64:33];
      item_r.encoder_position <= in_tdata[96:65];
      item_r.button_ok        <= in_tdata[97];
      item_r.button_level     <= in_tdata[98];
      item_r.display_ready    <= in_tdata[99];
      item_r.new_position     <= in_tdata[131:100];
    end
  end

  rbeq_eval u_eval (
    .item_i (item_r),
    .st_i   (state_r),
    .cfg_i  (cfg),
    .st_o   (state_nxt),
    .slot_o (slots),
    .mask_o (mask)
  );

  // Block state advances once per evaluated item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (load) begin
      state_r <= state_nxt;
    end
  end

  rbeq_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .slot_i     (slots),
    .mask_i     (mask),
    .free_o     (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_o      (res)
  );

  assign out_tuser = res.event_kind;
  assign out_tlast = res.last;
  assign out_tdata = {4'b0, res.recent_code, res.event_total, res.btn_down,
                      res.delta, res.position};

  // The buffer is reloaded only when empty or when its final item leaves.
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_tvalid || (out_tready && out_tlast)))
    else $error("result buffer reloaded while items remain");

  // Every evaluated item yields at least one result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("evaluated item produced no result");

  // A status item always closes its input.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == EV_STATUS) |-> out_tlast)
    else $error("status item without last flag");

endmodule
